@@ hw/rtl/rqb_pkg.sv @@
// shared types and codes of the retry queue with backoff
package rqb_pkg;

   localparam int TIME_BITS     = 32;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_ADDR_BITS = 2;
   localparam int LIMIT_BITS    = 7;
   localparam int DELAY_BITS    = 16;
   localparam int COUNT_BITS    = 2;
   localparam int KIND_BITS     = 3;
   localparam int OP_BITS       = 2;

   localparam logic [LIMIT_BITS-1:0] QUEUE_LIMIT_RESET = 7'd50;
   localparam logic [DELAY_BITS-1:0] BASE_DELAY_RESET  = 16'd2000;
   localparam logic [COUNT_BITS-1:0] MAX_RETRIES_RESET = 2'd3;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD   = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADDED   = 3'd0,
      KIND_FULL    = 3'd1,
      KIND_DUP     = 3'd2,
      KIND_CLEARED = 3'd3,
      KIND_RESEND  = 3'd4,
      KIND_EXPIRED = 3'd5,
      KIND_IDLE    = 3'd6
   } kind_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_QUEUE_LIMIT = 2'd0,
      CSR_BASE_DELAY  = 2'd1,
      CSR_MAX_RETRIES = 2'd2
   } csr_index_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic rd_main;
      logic add_next;
      logic add_commit;
      logic emit_full;
      logic emit_dup;
      logic tick_eval;
      logic move_start;
      logic rd_buf;
      logic move_write;
      logic tick_end;
      logic do_clear;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic scan_done;
      logic move_done;
      logic hit;
      logic tick_wait;
      logic out_free;
   } sts_type;

endpackage

@@ hw/rtl/retry_queue_with_backoff.sv @@
// top level of the retry queue with linear backoff
//
// Ordered retry table of message tags held in a single-port table memory plus a resend
// buffer of the same depth. One item is handled at a time; stall stays high until the
// item is finished. An add that finds the table not full walks the held entries for a
// duplicate tag, each entry by a registered memory read and then a compare. A tick
// reads and sorts every held entry, compacting kept entries in place and parking
// resends in the buffer, then copies the parked entries back behind the kept ones,
// waiting while the result side stalls. Results leave through an output register, one
// per transfer; the last result of an item has last set.
module retry_queue_with_backoff #(
   parameter int TABLE_DEPTH = 64,
   parameter int TAG_BITS    = 32,
   parameter int HANDLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rqb_pkg::OP_BITS-1:0]       req_op,
   input  logic [TAG_BITS-1:0]               req_message_tag,
   input  logic [HANDLE_BITS-1:0]            req_payload_handle,
   input  logic [rqb_pkg::TIME_BITS-1:0]     req_now_ms,
   input  logic                              csr_we,
   input  logic [rqb_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [rqb_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rqb_pkg::KIND_BITS-1:0]     rsp_kind,
   output logic [TAG_BITS-1:0]               rsp_out_tag,
   output logic [HANDLE_BITS-1:0]            rsp_out_handle,
   output logic [rqb_pkg::COUNT_BITS-1:0]    rsp_attempt,
   output logic                              rsp_last
);

   rqb_pkg::cmd_type cmd;
   rqb_pkg::sts_type sts;

   rqb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rqb_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TAG_BITS    (TAG_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_message_tag    (req_message_tag),
      .req_payload_handle (req_payload_handle),
      .req_now_ms         (req_now_ms),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_attempt        (rsp_attempt),
      .rsp_last           (rsp_last)
   );

endmodule

@@ hw/rtl/rqb_ctrl.sv @@
// sequencer of the retry queue: add search, tick scan, re-append and clear
module rqb_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [rqb_pkg::OP_BITS-1:0]      req_op,
   output logic                             req_stall,
   input  rqb_pkg::sts_type                 sts,
   output rqb_pkg::cmd_type                 cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ADD_CHK  = 9'b000000010,
      ST_ADD_EV   = 9'b000000100,
      ST_TICK_RD  = 9'b000001000,
      ST_TICK_EV  = 9'b000010000,
      ST_MOVE_RD  = 9'b000100000,
      ST_MOVE_WR  = 9'b001000000,
      ST_TICK_END = 9'b010000000,
      ST_CLEAR    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_op)
                  rqb_pkg::OP_ADD:   state_in = ST_ADD_CHK;
                  rqb_pkg::OP_TICK:  state_in = ST_TICK_RD;
                  rqb_pkg::OP_CLEAR: state_in = ST_CLEAR;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_CHK: begin
            if (sts.full) begin
               if (sts.out_free) begin
                  cmd.emit_full = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (sts.scan_done) begin
               if (sts.out_free) begin
                  cmd.add_commit = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.rd_main = 1'b1;
               state_in    = ST_ADD_EV;
            end
         end
         ST_ADD_EV: begin
            if (sts.hit) begin
               if (sts.out_free) begin
                  cmd.emit_dup = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.add_next = 1'b1;
               state_in     = ST_ADD_CHK;
            end
         end
         ST_TICK_RD: begin
            if (sts.scan_done) begin
               cmd.move_start = 1'b1;
               state_in       = ST_MOVE_RD;
            end else begin
               cmd.rd_main = 1'b1;
               state_in    = ST_TICK_EV;
            end
         end
         ST_TICK_EV: begin
            if (!sts.tick_wait) begin
               cmd.tick_eval = 1'b1;
               state_in      = ST_TICK_RD;
            end
         end
         ST_MOVE_RD: begin
            if (sts.move_done) begin
               state_in = ST_TICK_END;
            end else begin
               cmd.rd_buf = 1'b1;
               state_in   = ST_MOVE_WR;
            end
         end
         ST_MOVE_WR: begin
            cmd.move_write = 1'b1;
            state_in       = ST_MOVE_RD;
         end
         ST_TICK_END: begin
            if (sts.out_free) begin
               cmd.tick_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (sts.out_free) begin
               cmd.do_clear = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/rqb_dp.sv @@
// datapath of the retry queue: entry table, resend buffer, counters, result register
module rqb_dp #(
   parameter int TABLE_DEPTH = 64,
   parameter int TAG_BITS    = 32,
   parameter int HANDLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [TAG_BITS-1:0]                 req_message_tag,
   input  logic [HANDLE_BITS-1:0]              req_payload_handle,
   input  logic [rqb_pkg::TIME_BITS-1:0]       req_now_ms,
   input  logic                                csr_we,
   input  logic [rqb_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [rqb_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  rqb_pkg::cmd_type                    cmd,
   output rqb_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rqb_pkg::KIND_BITS-1:0]       rsp_kind,
   output logic [TAG_BITS-1:0]                 rsp_out_tag,
   output logic [HANDLE_BITS-1:0]              rsp_out_handle,
   output logic [rqb_pkg::COUNT_BITS-1:0]      rsp_attempt,
   output logic                                rsp_last
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = (CW > rqb_pkg::LIMIT_BITS) ? CW : rqb_pkg::LIMIT_BITS;
   localparam int TW = rqb_pkg::TIME_BITS;
   localparam int NB = rqb_pkg::COUNT_BITS;
   localparam int EW = TAG_BITS + HANDLE_BITS + NB + TW;
   localparam int PW = rqb_pkg::DELAY_BITS + 3;

   // configuration
   logic [rqb_pkg::LIMIT_BITS-1:0] queue_limit_ff;
   logic [rqb_pkg::DELAY_BITS-1:0] base_delay_ff;
   logic [NB-1:0]                  max_retries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff <= rqb_pkg::QUEUE_LIMIT_RESET;
         base_delay_ff  <= rqb_pkg::BASE_DELAY_RESET;
         max_retries_ff <= rqb_pkg::MAX_RETRIES_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            rqb_pkg::CSR_QUEUE_LIMIT: queue_limit_ff <= csr_wdata[rqb_pkg::LIMIT_BITS-1:0];
            rqb_pkg::CSR_BASE_DELAY:  base_delay_ff  <= csr_wdata[rqb_pkg::DELAY_BITS-1:0];
            rqb_pkg::CSR_MAX_RETRIES: max_retries_ff <= csr_wdata[NB-1:0];
            default: begin
            end
         endcase
      end
   end

   // item registers
   logic [TAG_BITS-1:0]    tag_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [TW-1:0]          now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff    <= req_message_tag;
         handle_ff <= req_payload_handle;
         now_ff    <= req_now_ms;
      end
   end

   // counters
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] nr_ff, nr_in;

   // memories
   logic [EW-1:0] main_mem_ff [TABLE_DEPTH];
   logic [EW-1:0] buf_mem_ff [TABLE_DEPTH];
   logic [EW-1:0] main_rd_ff;
   logic [EW-1:0] buf_rd_ff;

   logic [TAG_BITS-1:0]    rd_tag;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [NB-1:0]          rd_cnt;
   logic [TW-1:0]          rd_due;
   logic                   rd_is_due;
   logic                   rd_expire;
   logic [NB-1:0]          new_cnt;
   logic [2:0]             factor;
   logic [PW-1:0]          backoff;
   logic [TW-1:0]          new_due;

   assign rd_tag    = main_rd_ff[EW-1 -: TAG_BITS];
   assign rd_handle = main_rd_ff[NB+TW +: HANDLE_BITS];
   assign rd_cnt    = main_rd_ff[TW +: NB];
   assign rd_due    = main_rd_ff[TW-1:0];
   assign rd_is_due = (now_ff >= rd_due);
   assign rd_expire = (rd_cnt >= max_retries_ff);
   assign new_cnt   = rd_cnt + NB'(1);
   assign factor    = 3'(new_cnt) + 3'd1;
   assign backoff   = PW'(base_delay_ff) * PW'(factor);
   assign new_due   = now_ff + TW'(backoff);

   logic          main_we;
   logic [AW-1:0] main_waddr;
   logic [EW-1:0] main_wdata;
   logic          buf_we;
   logic [EW-1:0] buf_wdata;

   always_comb begin
      main_we    = 1'b0;
      main_waddr = keep_ff[AW-1:0];
      main_wdata = main_rd_ff;
      if (cmd.add_commit) begin
         main_we    = 1'b1;
         main_waddr = occ_ff[AW-1:0];
         main_wdata = {tag_ff, handle_ff, NB'(0), now_ff + TW'(base_delay_ff)};
      end else if (cmd.tick_eval && !rd_is_due) begin
         main_we = 1'b1;
      end else if (cmd.move_write) begin
         main_we    = 1'b1;
         main_wdata = buf_rd_ff;
      end
   end

   assign buf_we    = cmd.tick_eval && rd_is_due && !rd_expire;
   assign buf_wdata = {rd_tag, rd_handle, new_cnt, new_due};

   always_ff @(posedge clock) begin
      if (main_we) begin
         main_mem_ff[main_waddr] <= main_wdata;
      end
      if (cmd.rd_main) begin
         main_rd_ff <= main_mem_ff[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem_ff[nr_ff[AW-1:0]] <= buf_wdata;
      end
      if (cmd.rd_buf) begin
         buf_rd_ff <= buf_mem_ff[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      occ_in  = occ_ff;
      idx_in  = idx_ff;
      keep_in = keep_ff;
      nr_in   = nr_ff;
      if (cmd.load || cmd.move_start) begin
         idx_in = '0;
      end
      if (cmd.load) begin
         keep_in = '0;
         nr_in   = '0;
      end
      if (cmd.add_next) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.add_commit) begin
         occ_in = occ_ff + CW'(1);
      end
      if (cmd.tick_eval) begin
         idx_in = idx_ff + CW'(1);
         if (!rd_is_due) begin
            keep_in = keep_ff + CW'(1);
         end else if (!rd_expire) begin
            nr_in = nr_ff + CW'(1);
         end
      end
      if (cmd.move_write) begin
         idx_in  = idx_ff + CW'(1);
         keep_in = keep_ff + CW'(1);
      end
      if (cmd.tick_end) begin
         occ_in = keep_ff;
      end
      if (cmd.do_clear) begin
         occ_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff  <= '0;
         idx_ff  <= '0;
         keep_ff <= '0;
         nr_ff   <= '0;
      end else begin
         occ_ff  <= occ_in;
         idx_ff  <= idx_in;
         keep_ff <= keep_in;
         nr_ff   <= nr_in;
      end
   end

   // a tick result is held back in a pending register so that the final one can carry last
   logic                            pend_valid_ff;
   logic [rqb_pkg::KIND_BITS-1:0]   pend_kind_ff;
   logic [TAG_BITS-1:0]             pend_tag_ff;
   logic [HANDLE_BITS-1:0]          pend_handle_ff;
   logic [NB-1:0]                   pend_attempt_ff;

   logic out_free;
   logic tick_emit;

   assign out_free  = !rsp_valid || !rsp_stall;
   assign tick_emit = cmd.tick_eval && rd_is_due;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         pend_valid_ff <= 1'b0;
      end else if (tick_emit) begin
         pend_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_emit) begin
         pend_kind_ff    <= rd_expire ? rqb_pkg::KIND_EXPIRED : rqb_pkg::KIND_RESEND;
         pend_tag_ff     <= rd_tag;
         pend_handle_ff  <= rd_handle;
         pend_attempt_ff <= rd_expire ? rd_cnt : new_cnt;
      end
   end

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rqb_pkg::KIND_BITS-1:0] rsp_kind_ff, rsp_kind_in;
   logic [TAG_BITS-1:0]           rsp_tag_ff, rsp_tag_in;
   logic [HANDLE_BITS-1:0]        rsp_handle_ff, rsp_handle_in;
   logic [NB-1:0]                 rsp_attempt_ff, rsp_attempt_in;
   logic                          rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_attempt_in = rsp_attempt_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.emit_full || cmd.emit_dup || cmd.add_commit) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = cmd.emit_full ? rqb_pkg::KIND_FULL :
                          cmd.emit_dup  ? rqb_pkg::KIND_DUP  : rqb_pkg::KIND_ADDED;
         rsp_tag_in     = tag_ff;
         rsp_handle_in  = '0;
         rsp_attempt_in = '0;
         rsp_last_in    = 1'b1;
      end else if (cmd.do_clear) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = rqb_pkg::KIND_CLEARED;
         rsp_tag_in     = '0;
         rsp_handle_in  = '0;
         rsp_attempt_in = '0;
         rsp_last_in    = 1'b1;
      end else if ((tick_emit && pend_valid_ff) || (cmd.tick_end && pend_valid_ff)) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = pend_kind_ff;
         rsp_tag_in     = pend_tag_ff;
         rsp_handle_in  = pend_handle_ff;
         rsp_attempt_in = pend_attempt_ff;
         rsp_last_in    = cmd.tick_end;
      end else if (cmd.tick_end) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = rqb_pkg::KIND_IDLE;
         rsp_tag_in     = '0;
         rsp_handle_in  = '0;
         rsp_attempt_in = '0;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_attempt_ff <= rsp_attempt_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_out_tag    = rsp_tag_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_attempt    = rsp_attempt_ff;
   assign rsp_last       = rsp_last_ff;

   // status
   logic [LW-1:0] limit_eff;
   assign limit_eff = (LW'(queue_limit_ff) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
                                                               : LW'(queue_limit_ff);

   assign sts.full      = (LW'(occ_ff) >= limit_eff);
   assign sts.scan_done = (idx_ff == occ_ff);
   assign sts.move_done = (idx_ff == nr_ff);
   assign sts.hit       = (rd_tag == tag_ff);
   assign sts.tick_wait = rd_is_due && pend_valid_ff && !out_free;
   assign sts.out_free  = out_free;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the retry queue with linear backoff
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      rqb_pkg::op_type op;
      logic [31:0]     tag;
      logic [15:0]     handle;
      logic [31:0]     now;
   } item_type;

   typedef struct {
      rqb_pkg::kind_type kind;
      logic [31:0]       tag;
      logic [15:0]       handle;
      logic [1:0]        attempt;
      logic              last;
   } result_type;

   localparam int DEPTH = 64;
   localparam int SETTLE_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [rqb_pkg::OP_BITS-1:0] req_op = rqb_pkg::OP_ADD;
   logic [31:0] req_message_tag = '0;
   logic [15:0] req_payload_handle = '0;
   logic [31:0] req_now_ms = '0;
   logic csr_we = 0;
   logic [rqb_pkg::CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [rqb_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [rqb_pkg::KIND_BITS-1:0] rsp_kind;
   logic [31:0] rsp_out_tag;
   logic [15:0] rsp_out_handle;
   logic [rqb_pkg::COUNT_BITS-1:0] rsp_attempt;
   logic rsp_last;

   retry_queue_with_backoff u_top (.*);

   always #6 clock = ~clock;

   // shadow of the retry table and its settings
   logic [31:0] sh_tags [DEPTH];
   logic [15:0] sh_handles [DEPTH];
   logic [1:0]  sh_counts [DEPTH];
   logic [31:0] sh_due [DEPTH];
   int          sh_occ = 0;
   logic [6:0]  cfg_limit = rqb_pkg::QUEUE_LIMIT_RESET;
   logic [15:0] cfg_delay = rqb_pkg::BASE_DELAY_RESET;
   logic [1:0]  cfg_retries = rqb_pkg::MAX_RETRIES_RESET;

   item_type   pending_items[$];
   result_type expected_results[$];
   item_type   cur_item;
   int      send_idle = 0;
   int      recv_stall = 0;
   int      errors = 0;
   int      quiet_cycles = 0;
   logic [31:0] clock_ms = 32'd0;
   logic [31:0] tag_pool [24];

   task automatic report(input string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   function automatic result_type mk(rqb_pkg::kind_type k, logic [31:0] t, logic [15:0] h,
                                     logic [1:0] a);
      result_type r;
      r.kind = k; r.tag = t; r.handle = h; r.attempt = a; r.last = 0;
      return r;
   endfunction

   // updates the shadow table and queues the results one item causes
   function automatic void predict_retry(item_type it);
      result_type res[$];
      logic [31:0] rt [DEPTH];
      logic [15:0] rh [DEPTH];
      logic [1:0]  rc [DEPTH];
      logic [31:0] rd [DEPTH];
      int keep, nr, lim;
      bit dup;
      logic [1:0] c;
      keep = 0; nr = 0; dup = 0;
      lim = (int'(cfg_limit) < DEPTH) ? int'(cfg_limit) : DEPTH;
      case (it.op)
         rqb_pkg::OP_ADD: begin
            if (sh_occ >= lim) res = {res, mk(rqb_pkg::KIND_FULL, it.tag, '0, '0)};
            else begin
               for (int i = 0; i < sh_occ; i++) if (sh_tags[i] == it.tag) dup = 1;
               if (dup) res = {res, mk(rqb_pkg::KIND_DUP, it.tag, '0, '0)};
               else begin
                  sh_tags[sh_occ] = it.tag;
                  sh_handles[sh_occ] = it.handle;
                  sh_counts[sh_occ] = '0;
                  sh_due[sh_occ] = it.now + 32'(cfg_delay);
                  sh_occ++;
                  res = {res, mk(rqb_pkg::KIND_ADDED, it.tag, '0, '0)};
               end
            end
         end
         rqb_pkg::OP_TICK: begin
            for (int i = 0; i < sh_occ; i++) begin
               if (it.now >= sh_due[i]) begin
                  c = sh_counts[i];
                  if (c >= cfg_retries)
                     res = {res, mk(rqb_pkg::KIND_EXPIRED, sh_tags[i], sh_handles[i], c)};
                  else begin
                     c = c + 2'd1;
                     rt[nr] = sh_tags[i]; rh[nr] = sh_handles[i]; rc[nr] = c;
                     rd[nr] = it.now + 32'(cfg_delay) * (32'(c) + 32'd1);
                     nr++;
                     res = {res, mk(rqb_pkg::KIND_RESEND, sh_tags[i], sh_handles[i], c)};
                  end
               end else begin
                  sh_tags[keep] = sh_tags[i]; sh_handles[keep] = sh_handles[i];
                  sh_counts[keep] = sh_counts[i]; sh_due[keep] = sh_due[i];
                  keep++;
               end
            end
            for (int i = 0; i < nr; i++) begin
               sh_tags[keep] = rt[i]; sh_handles[keep] = rh[i];
               sh_counts[keep] = rc[i]; sh_due[keep] = rd[i];
               keep++;
            end
            sh_occ = keep;
            if (res.size() == 0) res = {res, mk(rqb_pkg::KIND_IDLE, '0, '0, '0)};
         end
         rqb_pkg::OP_CLEAR: begin
            sh_occ = 0;
            res = {res, mk(rqb_pkg::KIND_CLEARED, '0, '0, '0)};
         end
         default: ;
      endcase
      if (res.size() > 0) begin
         res[res.size()-1].last = 1;
         foreach (res[i]) expected_results = {expected_results, res[i]};
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) predict_retry(cur_item);
         if (!req_valid || !req_stall) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
               cur_item = pending_items.pop_front();
               req_op <= cur_item.op;
               req_message_tag <= cur_item.tag;
               req_payload_handle <= cur_item.handle;
               req_now_ms <= cur_item.now;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report($sformatf("unexpected result kind %0d tag %h", rsp_kind, rsp_out_tag));
            end else begin
               e = expected_results.pop_front();
               if (rsp_kind !== e.kind || rsp_out_tag !== e.tag ||
                   rsp_out_handle !== e.handle || rsp_attempt !== e.attempt ||
                   rsp_last !== e.last)
                  report($sformatf("got %0d/%h/%h/%0d/%0b want %0d/%h/%h/%0d/%0b",
                     rsp_kind, rsp_out_tag, rsp_out_handle, rsp_attempt, rsp_last,
                     e.kind, e.tag, e.handle, e.attempt, e.last));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic push_item(rqb_pkg::op_type op, logic [31:0] tag, logic [15:0] handle,
                            logic [31:0] now);
      item_type it;
      it.op = op; it.tag = tag; it.handle = handle; it.now = now;
      pending_items = {pending_items, it};
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(rqb_pkg::csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1; csr_addr <= idx; csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         rqb_pkg::CSR_QUEUE_LIMIT: cfg_limit = value[6:0];
         rqb_pkg::CSR_BASE_DELAY:  cfg_delay = value;
         default:                  cfg_retries = value[1:0];
      endcase
   endtask

   task automatic setup(logic [6:0] lim, logic [15:0] delay, logic [1:0] retries,
                        int s_idle, int r_stall);
      drain();
      write_csr(rqb_pkg::CSR_QUEUE_LIMIT, 16'(lim));
      write_csr(rqb_pkg::CSR_BASE_DELAY, delay);
      write_csr(rqb_pkg::CSR_MAX_RETRIES, 16'(retries));
      send_idle = s_idle;
      recv_stall = r_stall;
   endtask

   task automatic random_items(int n);
      int r;
      logic [31:0] tag;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         clock_ms = clock_ms + $urandom_range(0, 3 * int'(cfg_delay) + 20);
         tag = ($urandom_range(9) == 0) ? $urandom : tag_pool[$urandom_range(23)];
         if (r < 45) push_item(rqb_pkg::OP_ADD, tag, 16'($urandom), clock_ms);
         else if (r < 88) push_item(rqb_pkg::OP_TICK, $urandom, 16'($urandom), clock_ms);
         else if (r < 93) push_item(rqb_pkg::OP_TICK, $urandom, 16'($urandom), $urandom);
         else if (r < 97) push_item(rqb_pkg::OP_CLEAR, $urandom, 16'($urandom), $urandom);
         else push_item(rqb_pkg::OP_NONE, $urandom, 16'($urandom), $urandom);
      end
   endtask

   initial begin
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: extremes, duplicates, time wrap, unused opcode, clear
      push_item(rqb_pkg::OP_TICK, '0, '0, '0);
      push_item(rqb_pkg::OP_ADD, 32'h0, 16'h0, 32'h0);
      push_item(rqb_pkg::OP_ADD, 32'hffff_ffff, 16'hffff, 32'hffff_f000);
      push_item(rqb_pkg::OP_ADD, 32'h0, 16'h1234, 32'h5);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'd100);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'hffff_ffff);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'hffff_ffff);
      push_item(rqb_pkg::OP_NONE, 32'h55, 16'h55, 32'h55);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'hffff_ffff);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'hffff_ffff);
      push_item(rqb_pkg::OP_CLEAR, '0, '0, '0);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'hffff_ffff);

      // zero limit, then full before duplicate
      setup(7'd0, 16'd0, 2'd0, 0, 0);
      push_item(rqb_pkg::OP_ADD, 32'ha5a5_a5a5, 16'h5a5a, '0);
      setup(7'd2, 16'd0, 2'd0, 0, 0);
      push_item(rqb_pkg::OP_ADD, 32'h1, 16'h1, '0);
      push_item(rqb_pkg::OP_ADD, 32'h2, 16'h2, '0);
      push_item(rqb_pkg::OP_ADD, 32'h1, 16'h3, '0);
      // limit lowered below occupancy, both entries still scanned and expire
      setup(7'd1, 16'd0, 2'd0, 0, 0);
      push_item(rqb_pkg::OP_ADD, 32'h3, 16'h3, '0);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'd0);
      push_item(rqb_pkg::OP_TICK, '0, '0, 32'd0);

      // random phases over settings and idle patterns
      clock_ms = 32'hffff_0000;
      setup(7'd64, 16'd2000, 2'd3, 0, 0);
      random_items(25);
      setup(7'd64, 16'd0, 2'd3, 69, 0);
      for (int i = 0; i < 40; i++)
         push_item(rqb_pkg::OP_ADD, $urandom, 16'($urandom), clock_ms);
      random_items(15);
      // count above a lowered retry limit
      setup(7'd50, 16'd65535, 2'd1, 0, 69);
      random_items(20);
      setup(7'd8, 16'd100, 2'd0, 36, 36);
      random_items(20);
      setup(7'd127, 16'd300, 2'd2, 36, 36);
      random_items(15);
      setup(7'd20, 16'd50, 2'd3, 0, 0);
      random_items(15);

      drain();
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
